// ----- hdl/table_linear_interpolator_core_assert.svh -----
`ifndef TABLE_LINEAR_INTERPOLATOR_CORE_ASSERT_SVH
`define TABLE_LINEAR_INTERPOLATOR_CORE_ASSERT_SVH

// antecedent implies consequent on the same edge
`define TLI_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tli: implication violated");

// condition must never be seen
`define TLI_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("tli: forbidden condition seen");

`endif

// ----- hdl/tli_pkg.sv -----
package tli_pkg;

  localparam int unsigned TABLE_DEPTH = 256;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam int unsigned IDX_W  = 8;
  localparam int unsigned X_W    = 32;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned SIZE_W = 9;
  localparam int unsigned ST_W   = 3;

  localparam int unsigned S_DATA_W = 72;
  localparam int unsigned M_DATA_W = 32;

  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_QUERY = 1'b1
  } tli_kind_e;

  typedef enum logic [ST_W-1:0] {
    ST_INTERP = 3'd0,
    ST_LOW    = 3'd1,
    ST_HIGH   = 3'd2,
    ST_NOSEG  = 3'd3,
    ST_EMPTY  = 3'd4
  } tli_status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHK0,
    S_CHKN,
    S_SCAN,
    S_PREP,
    S_ABS,
    S_MUL,
    S_DSTART,
    S_DIV
  } tli_state_e;

  typedef struct packed {
    tli_kind_e        kind;
    logic [IDX_W-1:0] idx;
    logic [X_W-1:0]   x;
    logic [VAL_W-1:0] val;
  } tli_cmd_t;

  typedef struct packed {
    logic busy;
    logic div_busy;
  } tli_stat_t;

endpackage

// ----- hdl/table_linear_interpolator_core.sv -----
// channel  | handshake                     | payload (lowest bit first)
// s_axis   | s_axis_tvalid / s_axis_tready | tdata: entry_index, point_x, point_value; tuser: mode
// m_axis   | m_axis_tvalid / m_axis_tready | tdata: interp_value; tuser: status
// cfg      | cfg_we_i, no wait             | cfg_wdata_i: table_size
//
// a load is written to the table from the idle state, a query on an empty table gets status EMPTY there
// clamped queries end in the first or last entry check, a query with no segment ends after the scan
// an interpolation scans with one memory read per scan cycle, then passes the prep, abs and mul states
// and the 32-step shift-subtract divider
// asynchronous active-low reset clears the table size, the queue, the sequencer and the output
// a query leaves the queue once the output register is free; meanwhile the queue takes transfers
`include "table_linear_interpolator_core_assert.svh"

module table_linear_interpolator_core #(
  parameter int unsigned TABLE_DEPTH = tli_pkg::TABLE_DEPTH,
  parameter int unsigned QUEUE_DEPTH = tli_pkg::QUEUE_DEPTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [tli_pkg::SIZE_W-1:0]   cfg_wdata_i,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // entry_index [7:0], point_x [39:8], point_value [71:40]
  input  logic [tli_pkg::S_DATA_W-1:0] s_axis_tdata,
  // mode [0]
  input  logic                         s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // interp_value [31:0]
  output logic [tli_pkg::M_DATA_W-1:0] m_axis_tdata,
  // status [2:0]
  output logic [tli_pkg::ST_W-1:0]     m_axis_tuser
);

  logic               q_push, q_full, q_valid, q_ready;
  tli_pkg::tli_cmd_t  push_cmd, head_cmd;
  tli_pkg::tli_stat_t stat;

  tli_front #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_push_o      (q_push),
    .q_full_i      (q_full),
    .q_cmd_o       (push_cmd)
  );

  tli_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_ready),
    .cmd_o   (head_cmd)
  );

  tli_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .q_valid_i     (q_valid),
    .q_ready_o     (q_ready),
    .q_cmd_i       (head_cmd),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .stat_o        (stat)
  );

  `TLI_ASSERT_NEVER(a_queue_no_overflow, clk_i, rst_ni, q_push && q_full)
  `TLI_ASSERT_IMP(a_div_only_in_query, clk_i, rst_ni, stat.div_busy, stat.busy)
  `TLI_ASSERT_IMP(a_out_empty_in_query, clk_i, rst_ni, stat.busy, !m_axis_tvalid)

endmodule

// ----- hdl/tli_front.sv -----
module tli_front #(
  parameter int unsigned TABLE_DEPTH = tli_pkg::TABLE_DEPTH
) (
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [tli_pkg::S_DATA_W-1:0] s_axis_tdata,
  input  logic                         s_axis_tuser,
  output logic                         q_push_o,
  input  logic                         q_full_i,
  output tli_pkg::tli_cmd_t            q_cmd_o
);

  logic idx_ok;
  logic xfer;

  assign s_axis_tready = !q_full_i;
  assign xfer          = s_axis_tvalid && !q_full_i;

  always_comb begin
    q_cmd_o.kind = tli_pkg::tli_kind_e'(s_axis_tuser);
    q_cmd_o.idx  = s_axis_tdata[7:0];
    q_cmd_o.x    = s_axis_tdata[39:8];
    q_cmd_o.val  = s_axis_tdata[71:40];
  end

  // loads aimed past the table are dropped here
  assign idx_ok   = 32'(q_cmd_o.idx) < TABLE_DEPTH;
  assign q_push_o = xfer && ((q_cmd_o.kind == tli_pkg::KIND_QUERY) || idx_ok);

endmodule

// ----- hdl/tli_queue.sv -----
module tli_queue #(
  parameter int unsigned DEPTH = tli_pkg::QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  tli_pkg::tli_cmd_t cmd_i,
  output logic              full_o,
  output logic              valid_o,
  input  logic              pop_i,
  output tli_pkg::tli_cmd_t cmd_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  tli_pkg::tli_cmd_t entries [DEPTH];
  logic [PW-1:0]     wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = cnt_q == CW'(DEPTH);
  assign valid_o = cnt_q != '0;
  assign cmd_o   = entries[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries[wptr_q] <= cmd_i;
    end
  end

endmodule

// ----- hdl/tli_div.sv -----
module tli_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dvd_i,
  input  logic [31:0] dvs_i,
  output logic        busy_o,
  output logic        done_o,
  output logic [31:0] quot_o
);

  localparam int unsigned STEPS = 32;
  localparam int unsigned SW    = $clog2(STEPS);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [SW-1:0] cnt_q, cnt_d;
  logic [31:0]   rem_q, lo_q, dvs_q;
  logic [32:0]   trial;
  logic [32:0]   diff;
  logic          ge;

  // upper half of the dividend is below the divisor, so 32 steps give the quotient
  assign trial = {rem_q, lo_q[31]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = SW'(STEPS - 1);
    end else if (busy_q) begin
      cnt_d = cnt_q - SW'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dvd_i[63:32];
      lo_q  <= dvd_i[31:0];
      dvs_q <= dvs_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[31:0] : trial[31:0];
      lo_q  <= {lo_q[30:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = lo_q;

endmodule

// ----- hdl/tli_back.sv -----
module tli_back #(
  parameter int unsigned TABLE_DEPTH = tli_pkg::TABLE_DEPTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [tli_pkg::SIZE_W-1:0]   cfg_wdata_i,
  input  logic                         q_valid_i,
  output logic                         q_ready_o,
  input  tli_pkg::tli_cmd_t            q_cmd_i,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [tli_pkg::M_DATA_W-1:0] m_axis_tdata,
  output logic [tli_pkg::ST_W-1:0]     m_axis_tuser,
  output tli_pkg::tli_stat_t           stat_o
);

  localparam int unsigned IW = $clog2(TABLE_DEPTH);
  localparam int unsigned NW = $clog2(TABLE_DEPTH + 1);

  tli_pkg::tli_state_e state_q, state_d;

  logic [63:0]   mem [TABLE_DEPTH];
  logic [63:0]   rdata_q;
  logic [IW-1:0] raddr;
  logic          we;
  logic [31:0]   rd_x, rd_y;

  logic [NW-1:0] size_q, size_d;
  logic [NW-1:0] rd_j_q, rd_j_d;

  logic [31:0] x_q, prev_x_q, prev_y_q, seg_x2_q, seg_y2_q;
  logic [31:0] den_q, num_q, mag_q;
  logic [32:0] dy_q;
  logic [32:0] mag_full;
  logic        neg_q;
  logic [63:0] prod_q;

  logic        div_start, div_busy, div_done;
  logic [31:0] div_quot;

  logic                 out_vld_q, out_vld_d;
  logic [31:0]          out_val_q;
  tli_pkg::tli_status_e out_st_q;
  logic                 out_load;
  logic [31:0]          out_val;
  tli_pkg::tli_status_e out_st;
  logic                 out_free;

  logic [33:0] sum;
  logic [31:0] sum_sat;

  assign rd_x     = rdata_q[31:0];
  assign rd_y     = rdata_q[63:32];
  assign out_free = !out_vld_q || m_axis_tready;
  assign mag_full = dy_q[32] ? (~dy_q + 33'd1) : dy_q;

  // y1 plus or minus the quotient, clamped to the signed 32-bit range
  assign sum = neg_q ? ({{2{prev_y_q[31]}}, prev_y_q} - {2'b00, div_quot})
                     : ({{2{prev_y_q[31]}}, prev_y_q} + {2'b00, div_quot});
  always_comb begin
    if (sum[33] && (sum[32:31] != 2'b11)) begin
      sum_sat = 32'h8000_0000;
    end else if (!sum[33] && (sum[32:31] != 2'b00)) begin
      sum_sat = 32'h7FFF_FFFF;
    end else begin
      sum_sat = sum[31:0];
    end
  end

  always_comb begin
    if (32'(cfg_wdata_i) > TABLE_DEPTH) begin
      size_d = NW'(TABLE_DEPTH);
    end else begin
      size_d = NW'(cfg_wdata_i);
    end
  end

  always_comb begin
    state_d   = state_q;
    rd_j_d    = rd_j_q;
    raddr     = '0;
    we        = 1'b0;
    q_ready_o = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    out_val   = '0;
    out_st    = tli_pkg::ST_NOSEG;
    case (state_q)
      tli_pkg::S_IDLE: begin
        q_ready_o = (q_cmd_i.kind == tli_pkg::KIND_LOAD) || out_free;
        if (q_valid_i && q_ready_o) begin
          if (q_cmd_i.kind == tli_pkg::KIND_LOAD) begin
            we = 1'b1;
          end else if (size_q == '0) begin
            out_load = 1'b1;
            out_st   = tli_pkg::ST_EMPTY;
          end else begin
            state_d = tli_pkg::S_CHK0;
          end
        end
      end
      tli_pkg::S_CHK0: begin
        if (x_q <= rd_x) begin
          out_load = 1'b1;
          out_val  = rd_y;
          out_st   = tli_pkg::ST_LOW;
          state_d  = tli_pkg::S_IDLE;
        end else if (size_q == NW'(1)) begin
          out_load = 1'b1;
          out_val  = rd_y;
          out_st   = tli_pkg::ST_HIGH;
          state_d  = tli_pkg::S_IDLE;
        end else begin
          raddr   = IW'(size_q - NW'(1));
          state_d = tli_pkg::S_CHKN;
        end
      end
      tli_pkg::S_CHKN: begin
        if (x_q >= rd_x) begin
          out_load = 1'b1;
          out_val  = rd_y;
          out_st   = tli_pkg::ST_HIGH;
          state_d  = tli_pkg::S_IDLE;
        end else begin
          raddr   = IW'(1);
          rd_j_d  = NW'(2);
          state_d = tli_pkg::S_SCAN;
        end
      end
      tli_pkg::S_SCAN: begin
        // one read issued per cycle while entries remain, data returns from the registered port in the following cycle
        if (rd_j_q < size_q) begin
          raddr  = rd_j_q[IW-1:0];
          rd_j_d = rd_j_q + NW'(1);
        end
        if ((x_q >= prev_x_q) && (x_q <= rd_x)) begin
          state_d = tli_pkg::S_PREP;
        end else if (rd_j_q == size_q) begin
          out_load = 1'b1;
          out_st   = tli_pkg::ST_NOSEG;
          state_d  = tli_pkg::S_IDLE;
        end
      end
      tli_pkg::S_PREP: begin
        state_d = tli_pkg::S_ABS;
      end
      tli_pkg::S_ABS: begin
        // zero-width segment holds y1
        if (den_q == '0) begin
          out_load = 1'b1;
          out_val  = prev_y_q;
          out_st   = tli_pkg::ST_INTERP;
          state_d  = tli_pkg::S_IDLE;
        end else begin
          state_d = tli_pkg::S_MUL;
        end
      end
      tli_pkg::S_MUL: begin
        state_d = tli_pkg::S_DSTART;
      end
      tli_pkg::S_DSTART: begin
        div_start = 1'b1;
        state_d   = tli_pkg::S_DIV;
      end
      tli_pkg::S_DIV: begin
        if (div_done) begin
          out_load = 1'b1;
          out_val  = sum_sat;
          out_st   = tli_pkg::ST_INTERP;
          state_d  = tli_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = tli_pkg::S_IDLE;
      end
    endcase
  end

  assign out_vld_d = out_load || (out_vld_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= tli_pkg::S_IDLE;
      size_q    <= '0;
      rd_j_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_j_q    <= rd_j_d;
      out_vld_q <= out_vld_d;
      if (cfg_we_i) begin
        size_q <= size_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[IW'(q_cmd_i.idx)] <= {q_cmd_i.val, q_cmd_i.x};
    end
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == tli_pkg::S_IDLE) && q_valid_i && q_ready_o) begin
      x_q <= q_cmd_i.x;
    end
    if (state_q == tli_pkg::S_CHK0) begin
      prev_x_q <= rd_x;
      prev_y_q <= rd_y;
    end
    if (state_q == tli_pkg::S_SCAN) begin
      if ((x_q >= prev_x_q) && (x_q <= rd_x)) begin
        seg_x2_q <= rd_x;
        seg_y2_q <= rd_y;
      end else begin
        prev_x_q <= rd_x;
        prev_y_q <= rd_y;
      end
    end
    if (state_q == tli_pkg::S_PREP) begin
      den_q <= seg_x2_q - prev_x_q;
      num_q <= x_q - prev_x_q;
      dy_q  <= {seg_y2_q[31], seg_y2_q} - {prev_y_q[31], prev_y_q};
    end
    if (state_q == tli_pkg::S_ABS) begin
      mag_q <= mag_full[31:0];
      neg_q <= dy_q[32];
    end
    if (state_q == tli_pkg::S_MUL) begin
      prod_q <= 64'(mag_q) * 64'(num_q);
    end
    if (out_load) begin
      out_val_q <= out_val;
      out_st_q  <= out_st;
    end
  end

  tli_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .dvd_i   (prod_q),
    .dvs_i   (den_q),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign m_axis_tvalid   = out_vld_q;
  assign m_axis_tdata    = out_val_q;
  assign m_axis_tuser    = out_st_q;
  assign stat_o.busy     = state_q != tli_pkg::S_IDLE;
  assign stat_o.div_busy = div_busy;

endmodule
